FILE: src/csem_pkg.sv
package csem_pkg;

	// item codes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_ESTOP  = 2'd3
	} csem_op_t;

	typedef enum logic [3:0] {
		CAUSE_NONE        = 4'd0,
		CAUSE_SENSOR      = 4'd1,
		CAUSE_OVERVOLT    = 4'd2,
		CAUSE_OVERCURRENT = 4'd3,
		CAUSE_ENERGY      = 4'd4,
		CAUSE_DURATION    = 4'd5,
		CAUSE_UNPLUG      = 4'd6,
		CAUSE_FULL        = 4'd7,
		CAUSE_STOP        = 4'd8,
		CAUSE_ESTOP       = 4'd9
	} csem_cause_t;

	typedef enum logic [2:0] {
		REG_MAX_VOLTAGE  = 3'd0,
		REG_MAX_CURRENT  = 3'd1,
		REG_MIN_CURRENT  = 3'd2,
		REG_FULL_VOLTAGE = 3'd3,
		REG_FULL_CURRENT = 3'd4,
		REG_ENERGY_LIMIT = 3'd5,
		REG_DURATION_LIM = 3'd6
	} csem_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PMUL,
		S_PADD,
		S_PEST,
		S_PBACK,
		S_PFIX,
		S_EEST,
		S_EBACK,
		S_EFIX,
		S_EMUL1,
		S_EMUL2,
		S_TADD,
		S_TEST,
		S_TBACK,
		S_TFIX,
		S_SUM,
		S_ACC,
		S_SAFE,
		S_OUT
	} csem_state_t;

	// shared multiplier geometry
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 21;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int unsigned CFG_DATA_W = 40;
	localparam int unsigned ENERGY_W   = 40;

	localparam logic [31:0] GRACE_MS        = 32'd10000;
	localparam logic [31:0] UNPLUG_MS       = 32'd5000;
	localparam logic [31:0] FULL_CONFIRM_MS = 32'd30000;

	localparam logic [20:0] POWER_DIV  = 21'd1000000;
	localparam logic [32:0] POWER_BIAS = 33'd500000;
	localparam logic [20:0] MWH_UNIT   = 21'd3600;
	localparam logic [20:0] MS_PER_S   = 21'd1000;

	// reciprocals floor(2^k / d); estimate is exact or one low for numerators below 2^k
	localparam int unsigned PWR_SHIFT = 33;
	localparam int unsigned ELA_SHIFT = 32;
	localparam int unsigned REM_SHIFT = 24;
	localparam longint unsigned RCP_PWR_L = (64'd1 << PWR_SHIFT) / 64'd1000000;
	localparam longint unsigned RCP_ELA_L = (64'd1 << ELA_SHIFT) / 64'd3600;
	localparam longint unsigned RCP_REM_L = (64'd1 << REM_SHIFT) / 64'd3600;
	localparam logic [20:0] RCP_PWR = RCP_PWR_L[20:0];
	localparam logic [20:0] RCP_ELA = RCP_ELA_L[20:0];
	localparam logic [20:0] RCP_REM = RCP_REM_L[20:0];

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic [15:0] voltage_mv;
		logic [15:0] current_ma;
		logic        sensor_valid;
	} csem_in_t;

	typedef struct packed {
		logic        relay_closed;
		logic [3:0]  stop_cause;
		logic        start_refused;
		logic [12:0] power_w;
		logic [39:0] session_energy_mwh;
		logic [39:0] station_energy_mwh;
	} csem_out_t;

	typedef struct packed {
		logic [15:0] max_voltage_mv;
		logic [15:0] max_current_ma;
		logic [15:0] min_current_ma;
		logic [15:0] full_voltage_mv;
		logic [15:0] full_current_ma;
		logic [39:0] energy_limit_mwh;
		logic [22:0] duration_limit_s;
	} csem_cfg_t;

	typedef struct packed {
		csem_cause_t cause;
		logic [31:0] low_start_ms;
		logic [31:0] full_start_ms;
	} csem_safe_t;

endpackage

FILE: src/csem_mul.sv
module csem_mul (
	input  logic                             clk,
	input  logic                             en,
	input  logic [csem_pkg::MUL_A_W-1:0]     a,
	input  logic [csem_pkg::MUL_B_W-1:0]     b,
	output logic [csem_pkg::MUL_P_W-1:0]     p
);
	import csem_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	// product register, holds while not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign p = p_q;

endmodule

FILE: src/csem_safety.sv
module csem_safety (
	input  logic [31:0]          now_ms,
	input  logic [15:0]          mv,
	input  logic [15:0]          ma,
	input  logic                 valid,
	input  csem_pkg::csem_cfg_t  cfg,
	input  logic [39:0]          session_energy,
	input  logic [33:0]          duration_ms,
	input  logic [31:0]          session_start_ms,
	input  logic [31:0]          low_start_ms,
	input  logic [31:0]          full_start_ms,
	output csem_pkg::csem_safe_t res
);
	import csem_pkg::*;

	logic [31:0] since_start;
	logic        low_cond;
	logic [31:0] low_base;
	logic        low_hit;
	logic        full_cond;
	logic [31:0] full_base;
	logic        full_hit;

	assign since_start = now_ms - session_start_ms;

	// zero stamp means the timer is not running
	assign low_cond = (ma < cfg.min_current_ma) && (since_start >= GRACE_MS);
	assign low_base = (low_start_ms == '0) ? now_ms : low_start_ms;
	assign low_hit  = low_cond && ((now_ms - low_base) >= UNPLUG_MS);

	assign full_cond = (cfg.full_voltage_mv != '0) && (mv >= cfg.full_voltage_mv) &&
		(ma <= cfg.full_current_ma);
	assign full_base = (full_start_ms == '0) ? now_ms : full_start_ms;
	assign full_hit  = full_cond && ((now_ms - full_base) >= FULL_CONFIRM_MS);

	// first failing check wins, later timers keep their stamps
	always_comb begin
		res.cause         = CAUSE_NONE;
		res.low_start_ms  = low_start_ms;
		res.full_start_ms = full_start_ms;
		if (!valid) begin
			res.cause = CAUSE_SENSOR;
		end else if (mv > cfg.max_voltage_mv) begin
			res.cause = CAUSE_OVERVOLT;
		end else if (ma > cfg.max_current_ma) begin
			res.cause = CAUSE_OVERCURRENT;
		end else if (session_energy >= cfg.energy_limit_mwh) begin
			res.cause = CAUSE_ENERGY;
		end else if ({2'b00, since_start} >= duration_ms) begin
			res.cause = CAUSE_DURATION;
		end else begin
			res.low_start_ms = low_cond ? low_base : '0;
			if (low_hit) begin
				res.cause = CAUSE_UNPLUG;
			end else begin
				res.full_start_ms = full_cond ? full_base : '0;
				if (full_hit) begin
					res.cause = CAUSE_FULL;
				end
			end
		end
	end

endmodule

FILE: src/charge_session_energy_and_safety_monitor_unit.sv
// charge session energy and safety monitor
//
// input channel (in_valid/in_ready/in_data) takes one time-stamped event per beat:
// sample, start, stop or emergency stop. output channel (out_valid/out_ready/out_data)
// returns exactly one result beat per input beat, in order.
// configuration is a plain write port (cfg_wen, cfg_index, cfg_data), one register per
// write, taken at any edge; write it only while no event is in flight.
//
// one event is worked at a time by a small sequencer around a single registered
// multiplier; constant divides are reciprocal multiplies with one correction step.
// start/stop go straight to the output step; a sample with the relay open runs
// the power steps, one with the relay closed runs 17 sequencer steps through power,
// elapsed split, energy carry and safety check, then the output step. in_ready is
// high only while the sequencer is idle.
// results sit in an output register; a stalled receiver holds the sequencer in its
// output step and back-pressures the input channel, nothing is dropped.
// reset: relay open, energy totals, remainder and timer stamps zero, limits at their
// defaults (max voltage/current all ones, the rest zero), no result pending.
module charge_session_energy_and_safety_monitor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  csem_pkg::csem_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output csem_pkg::csem_out_t                 out_data,
	input  logic                                cfg_wen,
	input  logic [2:0]                          cfg_index,
	input  logic [csem_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import csem_pkg::*;

	csem_state_t state_q, state_nxt;

	// control / architectural state
	csem_cfg_t   cfg_q;
	logic        relay_q;
	logic [39:0] session_q;
	logic [39:0] station_q;
	logic [11:0] rem_q;
	logic [31:0] last_q;
	logic [31:0] start_q;
	logic [31:0] low_q;
	logic [31:0] full_q;
	logic        out_valid_q;
	csem_out_t   out_q;

	// event payload and working registers
	logic [31:0] now_q;
	logic [15:0] mv_q;
	logic [15:0] ma_q;
	logic        valid_q;
	csem_cause_t cause_q;
	logic        refused_q;
	logic [12:0] power_q;
	logic [31:0] elapsed_q;
	logic [32:0] num_q;
	logic [20:0] quo_q;
	logic [20:0] eq_q;
	logic [11:0] er_q;
	logic [32:0] hi_q;
	logic [33:0] add_q;

	// shared multiplier
	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	logic        accept;
	logic        out_load;
	logic [32:0] pwr_rem;
	logic [31:0] ela_rem;
	logic [23:0] t_rem;
	logic [40:0] sess_sum;
	logic [40:0] stat_sum;
	csem_safe_t  safe;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	csem_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// duration limit in ms is left in the product register by the sum step
	csem_safety u_safety (
		.now_ms           (now_q),
		.mv               (mv_q),
		.ma               (ma_q),
		.valid            (valid_q),
		.cfg              (cfg_q),
		.session_energy   (session_q),
		.duration_ms      (mul_p[33:0]),
		.session_start_ms (start_q),
		.low_start_ms     (low_q),
		.full_start_ms    (full_q),
		.res              (safe)
	);

	// correction residues of the three constant divides
	assign pwr_rem  = num_q - mul_p[32:0];
	assign ela_rem  = elapsed_q - mul_p[31:0];
	assign t_rem    = num_q[23:0] - mul_p[23:0];
	assign sess_sum = {1'b0, session_q} + 41'(add_q);
	assign stat_sum = {1'b0, station_q} + 41'(add_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (in_data.operation == OP_SAMPLE) ? S_PMUL : S_OUT;
				end
			end
			S_PMUL:  state_nxt = S_PADD;
			S_PADD:  state_nxt = S_PEST;
			S_PEST:  state_nxt = S_PBACK;
			S_PBACK: state_nxt = S_PFIX;
			S_PFIX:  state_nxt = relay_q ? S_EEST : S_OUT;
			S_EEST:  state_nxt = S_EBACK;
			S_EBACK: state_nxt = S_EFIX;
			S_EFIX:  state_nxt = S_EMUL1;
			S_EMUL1: state_nxt = S_EMUL2;
			S_EMUL2: state_nxt = S_TADD;
			S_TADD:  state_nxt = S_TEST;
			S_TEST:  state_nxt = S_TBACK;
			S_TBACK: state_nxt = S_TFIX;
			S_TFIX:  state_nxt = S_SUM;
			S_SUM:   state_nxt = S_ACC;
			S_ACC:   state_nxt = S_SAFE;
			S_SAFE:  state_nxt = S_OUT;
			S_OUT: begin
				if (out_load) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// multiplier operand steering
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_PMUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(mv_q);
				mul_b  = MUL_B_W'(ma_q);
			end
			S_PEST: begin
				mul_en = 1'b1;
				mul_a  = num_q;
				mul_b  = RCP_PWR;
			end
			S_PBACK: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(mul_p >> PWR_SHIFT);
				mul_b  = POWER_DIV;
			end
			S_EEST: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(elapsed_q);
				mul_b  = RCP_ELA;
			end
			S_EBACK: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(mul_p >> ELA_SHIFT);
				mul_b  = MWH_UNIT;
			end
			S_EMUL1: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(power_q);
				mul_b  = eq_q;
			end
			S_EMUL2: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(power_q);
				mul_b  = MUL_B_W'(er_q);
			end
			S_TEST: begin
				mul_en = 1'b1;
				mul_a  = num_q;
				mul_b  = RCP_REM;
			end
			S_TBACK: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(mul_p >> REM_SHIFT);
				mul_b  = MWH_UNIT;
			end
			S_SUM: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(cfg_q.duration_limit_s);
				mul_b  = MS_PER_S;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_voltage_mv   <= '1;
			cfg_q.max_current_ma   <= '1;
			cfg_q.min_current_ma   <= '0;
			cfg_q.full_voltage_mv  <= '0;
			cfg_q.full_current_ma  <= '0;
			cfg_q.energy_limit_mwh <= '0;
			cfg_q.duration_limit_s <= '0;
		end else if (cfg_wen) begin
			unique case (csem_reg_t'(cfg_index))
				REG_MAX_VOLTAGE:  cfg_q.max_voltage_mv   <= cfg_data[15:0];
				REG_MAX_CURRENT:  cfg_q.max_current_ma   <= cfg_data[15:0];
				REG_MIN_CURRENT:  cfg_q.min_current_ma   <= cfg_data[15:0];
				REG_FULL_VOLTAGE: cfg_q.full_voltage_mv  <= cfg_data[15:0];
				REG_FULL_CURRENT: cfg_q.full_current_ma  <= cfg_data[15:0];
				REG_ENERGY_LIMIT: cfg_q.energy_limit_mwh <= cfg_data[39:0];
				REG_DURATION_LIM: cfg_q.duration_limit_s <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			relay_q     <= 1'b0;
			session_q   <= '0;
			station_q   <= '0;
			rem_q       <= '0;
			last_q      <= '0;
			start_q     <= '0;
			low_q       <= '0;
			full_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (csem_op_t'(in_data.operation))
							OP_START: begin
								if (!relay_q) begin
									session_q <= '0;
									rem_q     <= '0;
									start_q   <= in_data.now_ms;
									last_q    <= in_data.now_ms;
									low_q     <= '0;
									full_q    <= '0;
									relay_q   <= 1'b1;
								end
							end
							OP_STOP, OP_ESTOP: begin
								relay_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_PMUL: begin
					last_q <= now_q;
				end
				S_TFIX: begin
					rem_q <= (t_rem >= 24'(MWH_UNIT)) ? 12'(t_rem - 24'(MWH_UNIT)) : t_rem[11:0];
				end
				S_ACC: begin
					session_q <= sess_sum[40] ? '1 : sess_sum[39:0];
					station_q <= stat_sum[40] ? '1 : stat_sum[39:0];
				end
				S_SAFE: begin
					low_q  <= safe.low_start_ms;
					full_q <= safe.full_start_ms;
					if (safe.cause != CAUSE_NONE) begin
						relay_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					now_q     <= in_data.now_ms;
					valid_q   <= in_data.sensor_valid;
					mv_q      <= in_data.sensor_valid ? in_data.voltage_mv : '0;
					ma_q      <= in_data.sensor_valid ? in_data.current_ma : '0;
					power_q   <= '0;
					refused_q <= (in_data.operation == OP_START) && relay_q;
					case (csem_op_t'(in_data.operation))
						OP_STOP:  cause_q <= CAUSE_STOP;
						OP_ESTOP: cause_q <= CAUSE_ESTOP;
						default:  cause_q <= CAUSE_NONE;
					endcase
				end
			end
			S_PMUL: begin
				elapsed_q <= now_q - last_q;
			end
			S_PADD: begin
				num_q <= 33'(mul_p[31:0]) + POWER_BIAS;
			end
			S_PBACK: begin
				quo_q <= 21'(mul_p >> PWR_SHIFT);
			end
			S_PFIX: begin
				power_q <= quo_q[12:0] + 13'(pwr_rem >= 33'(POWER_DIV));
			end
			S_EBACK: begin
				quo_q <= 21'(mul_p >> ELA_SHIFT);
			end
			S_EFIX: begin
				if (ela_rem >= 32'(MWH_UNIT)) begin
					eq_q <= quo_q + 21'd1;
					er_q <= 12'(ela_rem - 32'(MWH_UNIT));
				end else begin
					eq_q <= quo_q;
					er_q <= ela_rem[11:0];
				end
			end
			S_EMUL2: begin
				hi_q <= mul_p[32:0];
			end
			S_TADD: begin
				num_q <= 33'(mul_p[23:0]) + 33'(rem_q);
			end
			S_TBACK: begin
				quo_q <= 21'(mul_p >> REM_SHIFT);
			end
			S_TFIX: begin
				quo_q <= quo_q + 21'(t_rem >= 24'(MWH_UNIT));
			end
			S_SUM: begin
				add_q <= 34'(hi_q) + 34'(quo_q);
			end
			S_SAFE: begin
				cause_q <= safe.cause;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.relay_closed       <= relay_q;
			out_q.stop_cause         <= cause_q;
			out_q.start_refused      <= refused_q;
			out_q.power_w            <= power_q;
			out_q.session_energy_mwh <= session_q;
			out_q.station_energy_mwh <= station_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// relay only closes on an accepted start
	a_relay_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_q) |-> $past(accept && (in_data.operation == OP_START)))
		else $error("relay closed without a start");

	// carry remainder stays below one mWh
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < 12'(MWH_UNIT))
		else $error("energy remainder out of range");

	// station total never drops
	a_station_mono: assert property (@(posedge clk) disable iff (!arst_n)
		station_q >= $past(station_q))
		else $error("station energy decreased");

	// session total bounded by station total
	a_session_le_station: assert property (@(posedge clk) disable iff (!arst_n)
		session_q <= station_q)
		else $error("session energy above station energy");

	// a reported cause means the relay is open
	a_cause_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.stop_cause == CAUSE_NONE) || !out_data.relay_closed)
		else $error("stop cause with relay closed");

endmodule

FILE: dv/session_result_checker.sv
module session_result_checker import csem_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  csem_in_t                 in_data,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  csem_out_t                out_data,
	input  logic                     cfg_wen,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       outstanding,
	output int                       failures,
	output int                       checked,
	output logic [15:0]              causes_seen
);

	// own copy of the limits and the session state
	csem_cfg_t   limits;
	logic        relay_on;
	logic [39:0] sess_mwh, stn_mwh;
	logic [63:0] carry_pms;
	logic [31:0] prev_sample_ms, sess_begin_ms, low_i_since_ms, full_since_ms;

	csem_out_t   readouts_due[$];
	int          fail_tally, readout_tally;
	logic [15:0] cause_mask;

	function automatic logic [39:0] add_capped(logic [39:0] total, logic [63:0] inc);
		logic [64:0] sum;
		sum = {25'd0, total} + {1'b0, inc};
		return (sum > 65'hFF_FFFF_FFFF) ? '1 : sum[39:0];
	endfunction

	function automatic csem_out_t next_readout(csem_in_t ev);
		csem_out_t   res;
		csem_cause_t cause;
		logic [15:0] mv, ma;
		logic [31:0] gap_ms, since_start;
		logic [63:0] watts, gained;
		res = '0;
		cause = CAUSE_NONE;
		watts = '0;
		mv = ev.sensor_valid ? ev.voltage_mv : 16'd0;
		ma = ev.sensor_valid ? ev.current_ma : 16'd0;
		case (csem_op_t'(ev.operation))
			OP_SAMPLE: begin
				gap_ms = ev.now_ms - prev_sample_ms;
				watts = (64'(mv) * 64'(ma) + 64'd500000) / 64'd1000000;
				prev_sample_ms = ev.now_ms;
				if (relay_on) begin
					carry_pms = carry_pms + watts * 64'(gap_ms);
					gained = carry_pms / 64'd3600;
					carry_pms = carry_pms % 64'd3600;
					sess_mwh = add_capped(sess_mwh, gained);
					stn_mwh = add_capped(stn_mwh, gained);
					since_start = ev.now_ms - sess_begin_ms;
					if (!ev.sensor_valid)
						cause = CAUSE_SENSOR;
					else if (mv > limits.max_voltage_mv)
						cause = CAUSE_OVERVOLT;
					else if (ma > limits.max_current_ma)
						cause = CAUSE_OVERCURRENT;
					else if (sess_mwh >= limits.energy_limit_mwh)
						cause = CAUSE_ENERGY;
					else if (since_start / 32'd1000 >= 32'(limits.duration_limit_s))
						cause = CAUSE_DURATION;
					else begin
						if (ma < limits.min_current_ma && since_start >= GRACE_MS) begin
							if (low_i_since_ms == '0)
								low_i_since_ms = ev.now_ms;
							if (ev.now_ms - low_i_since_ms >= UNPLUG_MS)
								cause = CAUSE_UNPLUG;
						end else begin
							low_i_since_ms = '0;
						end
						if (cause == CAUSE_NONE) begin
							if (limits.full_voltage_mv != '0 && mv >= limits.full_voltage_mv &&
							    ma <= limits.full_current_ma) begin
								if (full_since_ms == '0)
									full_since_ms = ev.now_ms;
								if (ev.now_ms - full_since_ms >= FULL_CONFIRM_MS)
									cause = CAUSE_FULL;
							end else begin
								full_since_ms = '0;
							end
						end
					end
					if (cause != CAUSE_NONE)
						relay_on = 1'b0;
				end
			end
			OP_START: begin
				if (relay_on) begin
					res.start_refused = 1'b1;
				end else begin
					sess_mwh = '0;
					carry_pms = '0;
					sess_begin_ms = ev.now_ms;
					prev_sample_ms = ev.now_ms;
					low_i_since_ms = '0;
					full_since_ms = '0;
					relay_on = 1'b1;
				end
			end
			default: begin
				relay_on = 1'b0;
				cause = (csem_op_t'(ev.operation) == OP_STOP) ? CAUSE_STOP : CAUSE_ESTOP;
			end
		endcase
		cause_mask[cause] = 1'b1;
		res.relay_closed = relay_on;
		res.stop_cause = cause;
		res.power_w = watts[12:0];
		res.session_energy_mwh = sess_mwh;
		res.station_energy_mwh = stn_mwh;
		return res;
	endfunction

	function automatic int field_differs(string what, int beat_no, logic [39:0] want,
	                                     logic [39:0] got);
		if (got === want)
			return 0;
		$display("%0t: readout %0d %s expected 0x%0h, got 0x%0h", $time, beat_no, what,
		         want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		csem_out_t want;
		if (!arst_n) begin
			limits.max_voltage_mv = 16'hFFFF;
			limits.max_current_ma = 16'hFFFF;
			limits.min_current_ma = '0;
			limits.full_voltage_mv = '0;
			limits.full_current_ma = '0;
			limits.energy_limit_mwh = '0;
			limits.duration_limit_s = '0;
			relay_on = 1'b0;
			sess_mwh = '0;
			stn_mwh = '0;
			carry_pms = '0;
			prev_sample_ms = '0;
			sess_begin_ms = '0;
			low_i_since_ms = '0;
			full_since_ms = '0;
			readouts_due.delete();
			fail_tally = 0;
			readout_tally = 0;
			cause_mask = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (readouts_due.size() == 0) begin
					$display("%0t: readout with no event outstanding, expected none, got 0x%0h",
					         $time, out_data);
					fail_tally++;
				end else begin
					want = readouts_due.pop_front();
					fail_tally += field_differs("relay_closed", readout_tally,
						40'(want.relay_closed), 40'(out_data.relay_closed));
					fail_tally += field_differs("stop_cause", readout_tally,
						40'(want.stop_cause), 40'(out_data.stop_cause));
					fail_tally += field_differs("start_refused", readout_tally,
						40'(want.start_refused), 40'(out_data.start_refused));
					fail_tally += field_differs("power_w", readout_tally,
						40'(want.power_w), 40'(out_data.power_w));
					fail_tally += field_differs("session_energy_mwh", readout_tally,
						want.session_energy_mwh, out_data.session_energy_mwh);
					fail_tally += field_differs("station_energy_mwh", readout_tally,
						want.station_energy_mwh, out_data.station_energy_mwh);
					readout_tally++;
				end
			end
			if (in_valid && in_ready)
				readouts_due.push_back(next_readout(in_data));
			if (cfg_wen) begin
				case (csem_reg_t'(cfg_index))
					REG_MAX_VOLTAGE:  limits.max_voltage_mv = cfg_data[15:0];
					REG_MAX_CURRENT:  limits.max_current_ma = cfg_data[15:0];
					REG_MIN_CURRENT:  limits.min_current_ma = cfg_data[15:0];
					REG_FULL_VOLTAGE: limits.full_voltage_mv = cfg_data[15:0];
					REG_FULL_CURRENT: limits.full_current_ma = cfg_data[15:0];
					REG_ENERGY_LIMIT: limits.energy_limit_mwh = cfg_data[39:0];
					REG_DURATION_LIM: limits.duration_limit_s = cfg_data[22:0];
					default: ;
				endcase
			end
		end
		outstanding <= readouts_due.size();
		failures <= fail_tally;
		checked <= readout_tally;
		causes_seen <= cause_mask;
	end

endmodule

FILE: dv/charge_session_energy_and_safety_monitor_unit_test.sv
module charge_session_energy_and_safety_monitor_unit_test;
	import csem_pkg::*;

	// edges with no traffic before the run is called hung; the slowest beat
	// (idle gap, busy sequencer, stalled sink) is far below this
	localparam int WATCHDOG_LIMIT = 1000;
	// settle time after the last readout, above the sample latency
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_EVENTS   = 217;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	csem_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	csem_out_t             out_data;
	logic                  cfg_wen   = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int          outstanding, failures, checked;
	logic [15:0] causes_seen;

	// limits as last written, used only to aim the stimulus
	csem_cfg_t   limits_now;
	logic [31:0] clock_ms        = '0;
	int          events_sent     = 0;
	int          settings_loaded = 0;
	bit          calm_send       = 1'b0;
	int          quiet_cycles    = 0;

	charge_session_energy_and_safety_monitor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	session_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.failures    (failures),
		.checked     (checked),
		.causes_seen (causes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hang detection: count edges where neither channel moves a beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d readouts outstanding", $time,
			         quiet_cycles, outstanding);
			$display("FAIL charge_session_energy_and_safety_monitor_unit");
			$finish;
		end
	end

	// readout sink: a fresh stall before every beat, with calm stretches
	initial begin : sink
		int stall;
		bit calm_recv;
		calm_recv = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm_recv = !calm_recv;
			stall = calm_recv ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one event beat; valid is only dropped when a gap is drawn, so back to
	// back beats never see two assignments in one step
	task automatic send_event(csem_op_t op, logic [31:0] at_ms, logic [15:0] mv,
	                          logic [15:0] ma, logic ok);
		csem_in_t beat;
		int gap;
		beat.operation = op;
		beat.now_ms = at_ms;
		beat.voltage_mv = mv;
		beat.current_ma = ma;
		beat.sensor_valid = ok;
		gap = calm_send ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		events_sent++;
	endtask

	// block is idle once every readout is back and the sequencer has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// rewrite all seven limit registers; junk above each narrower register's width
	// checks that the unused data bits are dropped
	task automatic switch_limits(csem_cfg_t lim);
		wait_idle();
		limits_now = lim;
		for (int r = REG_MAX_VOLTAGE; r <= REG_DURATION_LIM; r++) begin
			cfg_wen <= 1'b1;
			cfg_index <= r[2:0];
			case (csem_reg_t'(r))
				REG_MAX_VOLTAGE:  cfg_data <= {24'($urandom), lim.max_voltage_mv};
				REG_MAX_CURRENT:  cfg_data <= {24'($urandom), lim.max_current_ma};
				REG_MIN_CURRENT:  cfg_data <= {24'($urandom), lim.min_current_ma};
				REG_FULL_VOLTAGE: cfg_data <= {24'($urandom), lim.full_voltage_mv};
				REG_FULL_CURRENT: cfg_data <= {24'($urandom), lim.full_current_ma};
				REG_ENERGY_LIMIT: cfg_data <= lim.energy_limit_mwh;
				default:          cfg_data <= {17'($urandom), lim.duration_limit_s};
			endcase
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
		settings_loaded++;
	endtask

	// one charging session: a start, a run of samples shaped by a flavor,
	// some stray commands, and half the time a stop or emergency stop at the end
	task automatic play_session();
		int flavor, samples, pick;
		csem_op_t op;
		logic [15:0] mv, ma;
		logic ok;
		if ($urandom_range(0, 9) == 0)
			calm_send = !calm_send;
		// 0 mixed, 1 taper toward full, 2 plug pulled, 3 steady long steps
		flavor = $urandom_range(0, 3);
		clock_ms = clock_ms + $urandom_range(1, 5000);
		send_event(OP_START, clock_ms, $urandom, $urandom, $urandom);
		samples = (flavor == 1 || flavor == 2) ? $urandom_range(10, 60) : $urandom_range(1, 40);
		repeat (samples) begin
			pick = $urandom_range(0, 99);
			if (flavor == 3)
				clock_ms = clock_ms + $urandom_range(1000, 30000);
			else if (pick < 70)
				clock_ms = clock_ms + $urandom_range(1, 2000);
			else if (pick < 96)
				clock_ms = clock_ms + $urandom_range(2000, 20000);
			else
				clock_ms = $urandom;
			// a stamp of zero doubles as "timer not started"
			if ($urandom_range(0, 63) == 0)
				clock_ms = '0;
			if (flavor == 1 && limits_now.full_voltage_mv != '0 && $urandom_range(0, 9) != 0) begin
				mv = limits_now.full_voltage_mv +
				     ($urandom_range(0, 65535 - limits_now.full_voltage_mv) % 801);
				ma = $urandom_range(0, limits_now.full_current_ma);
			end else if (flavor == 2 && limits_now.min_current_ma != '0 &&
			             $urandom_range(0, 9) != 0) begin
				mv = $urandom_range(0, limits_now.max_voltage_mv);
				ma = $urandom_range(0, limits_now.min_current_ma - 1);
			end else begin
				case ($urandom_range(0, 9))
					0:       mv = $urandom;
					1, 2:    mv = limits_now.full_voltage_mv + 16'($urandom_range(0, 4000)) -
					              16'd2000;
					3:       mv = limits_now.max_voltage_mv + 16'($urandom_range(0, 2));
					default: mv = $urandom_range(0, limits_now.max_voltage_mv);
				endcase
				case ($urandom_range(0, 9))
					0:       ma = $urandom;
					1:       ma = $urandom_range(0, limits_now.full_current_ma);
					2:       ma = $urandom_range(0, limits_now.min_current_ma);
					3:       ma = limits_now.max_current_ma + 16'($urandom_range(0, 2));
					default: ma = $urandom_range(limits_now.min_current_ma,
					                             limits_now.max_current_ma);
				endcase
			end
			ok = ($urandom_range(0, 39) != 0);
			if ($urandom_range(0, 15) == 0)
				op = csem_op_t'($urandom_range(OP_START, OP_ESTOP));
			else
				op = OP_SAMPLE;
			send_event(op, clock_ms, mv, ma, ok);
		end
		case ($urandom_range(0, 3))
			0: send_event(OP_STOP, clock_ms + $urandom_range(0, 500), $urandom, $urandom, $urandom);
			1: send_event(OP_ESTOP, clock_ms + $urandom_range(0, 500), $urandom, $urandom,
			              $urandom);
			default: ;
		endcase
	endtask

	initial begin : stimulus
		csem_cfg_t lim;
		int phase_first;
		logic [31:0] t;

		limits_now = '{max_voltage_mv: 16'hFFFF, max_current_ma: 16'hFFFF, min_current_ma: '0,
		               full_voltage_mv: '0, full_current_ma: '0, energy_limit_mwh: '0,
		               duration_limit_s: '0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: open relay cases, then the zero energy limit
		send_event(OP_SAMPLE, 32'd1, 16'hFFFF, 16'hFFFF, 1'b1);   // top power, relay open
		send_event(OP_STOP, 32'd2, 16'h0000, 16'h0000, 1'b0);     // stop while open
		send_event(OP_ESTOP, 32'd3, 16'hFFFF, 16'hFFFF, 1'b1);    // emergency while open
		send_event(OP_START, 32'd0, 16'd0, 16'd0, 1'b0);          // session begins at time zero
		send_event(OP_START, 32'd50, 16'd0, 16'd0, 1'b1);         // refused, already closed
		send_event(OP_SAMPLE, 32'd100, 16'd1000, 16'd1000, 1'b1); // zero limit ends it

		// everything at its top value; the sample crosses the time wrap
		switch_limits('{max_voltage_mv: 16'hFFFF, max_current_ma: 16'hFFFF,
		               min_current_ma: 16'hFFFF, full_voltage_mv: 16'hFFFF,
		               full_current_ma: 16'hFFFF, energy_limit_mwh: '1, duration_limit_s: '1});
		send_event(OP_START, 32'hFFFF_F000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'h0000_0800, 16'hFFFF, 16'hFFFF, 1'b1);
		send_event(OP_SAMPLE, 32'h0000_0900, 16'hFFFF, 16'hFFFF, 1'b0); // sensor fault
		send_event(OP_START, 32'h0000_1000, 16'd0, 16'd0, 1'b1);
		send_event(OP_ESTOP, 32'h0000_1100, 16'd0, 16'd0, 1'b1);        // emergency while closed

		// mid limits: one session per safety cause
		switch_limits('{max_voltage_mv: 16'd50000, max_current_ma: 16'd40000,
		               min_current_ma: 16'd1000, full_voltage_mv: 16'd42000,
		               full_current_ma: 16'd500, energy_limit_mwh: 40'd1000,
		               duration_limit_s: 23'd100});
		send_event(OP_START, 32'd1000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd1100, 16'd50001, 16'd1000, 1'b1);      // overvoltage
		send_event(OP_START, 32'd2000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd2100, 16'd1, 16'd40001, 1'b1);         // overcurrent
		send_event(OP_START, 32'd3000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd5000, 16'd50000, 16'd40000, 1'b1);     // energy, at max v/i
		send_event(OP_START, 32'd10000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd110000, 16'd100, 16'd1000, 1'b1);      // duration
		// low current timer first stamped at zero, so it restarts a sample later
		send_event(OP_START, 32'hFFFF_D8F0, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd0, 16'd100, 16'd500, 1'b1);
		send_event(OP_SAMPLE, 32'd5000, 16'd100, 16'd500, 1'b1);
		send_event(OP_SAMPLE, 32'd10000, 16'd100, 16'd500, 1'b1);        // unplugged
		send_event(OP_START, 32'd200000, 16'd0, 16'd0, 1'b1);
		send_event(OP_SAMPLE, 32'd201000, 16'd42000, 16'd400, 1'b1);
		send_event(OP_SAMPLE, 32'd231000, 16'd42000, 16'd400, 1'b1);     // battery full
		clock_ms = 32'd300000;

		// random limit settings, each with a few hundred events of sessions
		repeat (6) begin
			case ($urandom_range(0, 15))
				0:       lim.max_voltage_mv = '0;
				1, 2:    lim.max_voltage_mv = '1;
				default: lim.max_voltage_mv = $urandom_range(35000, 65535);
			endcase
			case ($urandom_range(0, 15))
				0:       lim.max_current_ma = '0;
				1, 2:    lim.max_current_ma = '1;
				default: lim.max_current_ma = $urandom_range(20000, 65535);
			endcase
			case ($urandom_range(0, 3))
				0:       lim.min_current_ma = '0;
				1:       lim.min_current_ma = $urandom;
				default: lim.min_current_ma = $urandom_range(200, 3000);
			endcase
			lim.full_voltage_mv = ($urandom_range(0, 4) == 0) ? 16'd0 :
			                      16'($urandom_range(20000, 60000));
			lim.full_current_ma = ($urandom_range(0, 7) == 0) ? 16'hFFFF :
			                      16'($urandom_range(0, 2000));
			case ($urandom_range(0, 9))
				0:       lim.energy_limit_mwh = '0;
				1:       lim.energy_limit_mwh = '1;
				2:       lim.energy_limit_mwh = 40'({$urandom, $urandom});
				default: lim.energy_limit_mwh = $urandom_range(1, 3000);
			endcase
			case ($urandom_range(0, 9))
				0:       lim.duration_limit_s = '0;
				1:       lim.duration_limit_s = '1;
				default: lim.duration_limit_s = $urandom_range(1, 400);
			endcase
			switch_limits(lim);
			phase_first = events_sent;
			while (events_sent - phase_first < PHASE_EVENTS)
				play_session();
		end

		// full power over near-maximal gaps drives both totals into saturation;
		// the session ends on the energy limit once it pins at the top
		switch_limits('{max_voltage_mv: 16'hFFFF, max_current_ma: 16'hFFFF, min_current_ma: '0,
		               full_voltage_mv: '0, full_current_ma: '0, energy_limit_mwh: '1,
		               duration_limit_s: '1});
		t = clock_ms;
		send_event(OP_START, t, 16'd0, 16'd0, 1'b1);
		repeat (220) begin
			t = t - 32'd1;
			send_event(OP_SAMPLE, t, 16'hFFFF, 16'hFFFF, 1'b1);
		end

		wait_idle();
		$display("%0d events over %0d limit settings, %0d readouts checked", events_sent,
		         settings_loaded, checked);
		$display("stop causes reached: %0d of 9 (mask 0x%0h)", $countones(causes_seen[9:1]),
		         causes_seen);
		if (failures == 0 && outstanding == 0)
			$display("PASS charge_session_energy_and_safety_monitor_unit");
		else
			$display("FAIL charge_session_energy_and_safety_monitor_unit");
		$finish;
	end

endmodule
